// File: rtl/mstt_pkg.sv
// package for the multi-slot timer table: sizes, operation codes, slot entry layout
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

  // table geometry
  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 24;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = COUNT_BITS + 1;

  // stopped or never loaded count
  localparam logic signed [CNT_W-1:0] CNT_STOPPED = '1;

  // operation codes
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RESTART = 3'd2,
    OP_READ    = 3'd3,
    OP_SUSPEND = 3'd4,
    OP_NEWTIME = 3'd5,
    OP_KILL    = 3'd6
  } op_t;

  // expiry modes
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_FREE     = 2'd2;

  // one slot as held in the table memory
  typedef struct packed {
    logic [1:0]              mode;
    logic signed [CNT_W-1:0] reload;
    logic signed [CNT_W-1:0] remain;
    logic [31:0]             tag_a;
    logic [31:0]             tag_b;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/multi_slot_software_timer_table.sv
// multi-slot timer table: one slot memory with read-modify-write sequencer
// depends on mstt_pkg
// each command steps through read and evaluate states; write-back is in evaluate, pushes in evaluate or flush
// a tick walks slots 1 to SLOTS-1, each slot with a memory read, then an update,
// then a flush state and a return to idle; the walk holds when an expiry must push but the output stalls
// one input word at a time; the output register lets the next word in while a result waits
// reset clears the in-use flags, the sequencer and the output; the slot memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_software_timer_table
  import mstt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [3:0]         slot,
  input  wire logic [23:0]        count_value,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] arg_first,
  input  wire logic signed [31:0] arg_second,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              result_slot,
  output logic signed [24:0]      count_read,
  output logic                    fired,
  output logic signed [31:0]      tag_first_out,
  output logic signed [31:0]      tag_second_out,
  output logic                    last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [SLOTS-1:0]  in_use, in_use_next;

  // latched command word
  logic [2:0]              cmd_op;
  logic [3:0]              cmd_slot;
  logic                    cmd_slot_ok;
  logic signed [CNT_W-1:0] cmd_count;
  logic [1:0]              cmd_mode;
  logic [31:0]             cmd_tag_a;
  logic [31:0]             cmd_tag_b;

  // slot memory
  entry_t            mem [SLOTS];
  entry_t            rdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  // fired result held back until it is known whether another one follows
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_slot;
  logic [31:0]       pend_tag_a;
  logic [31:0]       pend_tag_b;
  logic              pend_set, pend_clr;

  // result word into the output register
  logic                    push;
  logic [3:0]              push_slot;
  logic signed [24:0]      push_count;
  logic                    push_fired;
  logic [31:0]             push_tag_a;
  logic [31:0]             push_tag_b;
  logic                    push_last;

  logic              out_free;
  logic              active;
  logic              counting;
  logic              hit;
  logic signed [CNT_W-1:0] rem_dec;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign active   = cmd_slot_ok && in_use[idx];

  // tick decision for the slot on hand
  assign counting = in_use[idx] && !rdata.remain[CNT_W-1] && (rdata.remain != '0);
  assign rem_dec  = rdata.remain - CNT_W'(1);
  assign hit      = counting && (rem_dec == '0);

  // lowest free slot above slot 0
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    in_use_next = in_use;
    mem_we      = 1'b0;
    mem_waddr   = idx;
    mem_wdata   = rdata;
    pend_set    = 1'b0;
    pend_clr    = 1'b0;
    push        = 1'b0;
    push_slot   = '0;
    push_count  = '0;
    push_fired  = 1'b0;
    push_tag_a  = '0;
    push_tag_b  = '0;
    push_last   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
          idx_next   = (operation == OP_TICK) ? FIRST_IDX : IDX_W'(slot);
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        unique case (cmd_op)
          OP_TICK: begin
            if (!(hit && pend_valid && !out_free)) begin
              if (counting) begin
                mem_we = 1'b1;
                if (hit) begin
                  mem_wdata.remain = (rdata.mode == MODE_PERIODIC) ? rdata.reload
                                                                   : CNT_STOPPED;
                  if (rdata.mode == MODE_FREE) begin
                    in_use_next[idx] = 1'b0;
                  end
                end else begin
                  mem_wdata.remain = rem_dec;
                end
              end
              // a new hit releases the older held result, not the last one
              if (hit) begin
                pend_set = 1'b1;
                if (pend_valid) begin
                  push       = 1'b1;
                  push_slot  = 4'(pend_slot);
                  push_fired = 1'b1;
                  push_tag_a = pend_tag_a;
                  push_tag_b = pend_tag_b;
                  push_last  = 1'b0;
                end
              end
              if (idx == LAST_IDX) begin
                state_next = ST_FLUSH;
              end else begin
                idx_next   = idx + IDX_W'(1);
                state_next = ST_READ;
              end
            end
          end
          OP_ALLOC: begin
            if (out_free) begin
              push      = 1'b1;
              push_slot = free_found ? 4'(free_idx) : 4'd0;
              if (free_found) begin
                mem_we              = 1'b1;
                mem_waddr           = free_idx;
                mem_wdata.mode      = cmd_mode;
                mem_wdata.reload    = cmd_count;
                mem_wdata.remain    = cmd_count;
                mem_wdata.tag_a     = cmd_tag_a;
                mem_wdata.tag_b     = cmd_tag_b;
                in_use_next[free_idx] = 1'b1;
              end
              state_next = ST_IDLE;
            end
          end
          OP_READ: begin
            if (out_free) begin
              push       = 1'b1;
              push_slot  = cmd_slot;
              push_count = active ? 25'(rdata.remain) : 25'(CNT_STOPPED);
              state_next = ST_IDLE;
            end
          end
          OP_RESTART: begin
            mem_we           = active;
            mem_wdata.remain = rdata.reload;
            state_next       = ST_IDLE;
          end
          OP_SUSPEND: begin
            mem_we           = active;
            mem_wdata.remain = CNT_STOPPED;
            state_next       = ST_IDLE;
          end
          OP_NEWTIME: begin
            mem_we           = active;
            mem_wdata.reload = cmd_count;
            mem_wdata.remain = cmd_count;
            state_next       = ST_IDLE;
          end
          OP_KILL: begin
            if (active) begin
              in_use_next[idx] = 1'b0;
            end
            state_next = ST_IDLE;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_slot  = 4'(pend_slot);
          push_fired = 1'b1;
          push_tag_a = pend_tag_a;
          push_tag_b = pend_tag_b;
          push_last  = 1'b1;
          pend_clr   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_use     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
      if (pend_set) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // slot index and command word
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == ST_IDLE && in_valid) begin
      cmd_op      <= operation;
      cmd_slot    <= slot;
      cmd_slot_ok <= (slot != 4'd0) && (32'(slot) < SLOTS);
      cmd_count   <= {1'b0, count_value[COUNT_BITS-1:0]};
      cmd_mode    <= mode;
      cmd_tag_a   <= arg_first;
      cmd_tag_b   <= arg_second;
    end
  end

  // held fired result
  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend_slot  <= idx;
      pend_tag_a <= rdata.tag_a;
      pend_tag_b <= rdata.tag_b;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (push) begin
      result_slot    <= push_slot;
      count_read     <= push_count;
      fired          <= push_fired;
      tag_first_out  <= push_tag_a;
      tag_second_out <= push_tag_b;
      last           <= push_last;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rdata <= mem[idx];
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_multi_slot_software_timer_table.sv
// self-checking testbench for the multi-slot timer table: directed table, then random words
// depends on mstt_pkg and multi_slot_software_timer_table
// a behavioral table predicts most result words, all checked in order at the output
`timescale 1ns / 1ps

module tb_multi_slot_software_timer_table;
  import mstt_pkg::*;

  localparam int          CLK_HALF       = 6;
  localparam int          RAND_WORDS     = 340;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 2 * (SLOTS - 1) + 10;
  localparam int          IDLE_PCT       = 24;
  localparam int          MAX_PRINTS     = 60;
  localparam logic [2:0]  OP_UNUSED      = 3'd7;
  localparam logic [1:0]  MODE_STOP      = 2'd0;
  localparam logic [1:0]  MODE_STOP_ALT  = 2'd3;

  // how a word's results are checked
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } check_kind_t;

  typedef struct packed {
    logic [3:0]              slot;
    logic signed [CNT_W-1:0] cnt;
    logic                    fired;
    logic [31:0]             tag_a;
    logic [31:0]             tag_b;
    logic                    last;
  } timer_result_t;

  typedef struct packed {
    logic [2:0]              op;
    logic [3:0]              slot;
    logic [23:0]             count;
    logic [1:0]              mode;
    logic [31:0]             a1;
    logic [31:0]             a2;
    check_kind_t             kind;
    logic [3:0]              exp_slot;
    logic signed [CNT_W-1:0] exp_cnt;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  // dut ports
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              operation = '0;
  logic [3:0]              slot = '0;
  logic [23:0]             count_value = '0;
  logic [1:0]              mode = '0;
  logic signed [31:0]      arg_first = '0;
  logic signed [31:0]      arg_second = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [3:0]              result_slot;
  logic signed [24:0]      count_read;
  logic                    fired;
  logic signed [31:0]      tag_first_out;
  logic signed [31:0]      tag_second_out;
  logic                    last;

  // check info that travels with the presented word
  check_kind_t             chk_kind = CHK_PREDICT;
  logic [3:0]              chk_slot = '0;
  logic signed [CNT_W-1:0] chk_cnt = '0;

  // predicted timer table
  bit                      slot_used [SLOTS];
  logic signed [CNT_W-1:0] reload_cnt [SLOTS];
  logic signed [CNT_W-1:0] remain_cnt [SLOTS];
  logic [1:0]              expiry [SLOTS];
  logic [31:0]             tag_a_tbl [SLOTS];
  logic [31:0]             tag_b_tbl [SLOTS];

  timer_result_t           word_results [$];
  timer_result_t           results_due [$];

  int                      errors = 0;
  int                      idle_cycles = 0;
  bit                      calm = 1'b0;
  stim_row_t               dir_rows [DIR_ROWS];

  multi_slot_software_timer_table dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .slot           (slot),
    .count_value    (count_value),
    .mode           (mode),
    .arg_first      (arg_first),
    .arg_second     (arg_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_slot    (result_slot),
    .count_read     (count_read),
    .fired          (fired),
    .tag_first_out  (tag_first_out),
    .tag_second_out (tag_second_out),
    .last           (last)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic timer_result_t make_result(input logic [3:0] s,
                                                input logic signed [CNT_W-1:0] c,
                                                input logic f, input logic [31:0] ta,
                                                input logic [31:0] tb2);
    timer_result_t r;
    r.slot  = s;
    r.cnt   = c;
    r.fired = f;
    r.tag_a = ta;
    r.tag_b = tb2;
    r.last  = 1'b0;
    return r;
  endfunction

  // table state after reset
  task automatic clear_timer_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      reload_cnt[i] = CNT_STOPPED;
      remain_cnt[i] = CNT_STOPPED;
      expiry[i]     = MODE_STOP;
      tag_a_tbl[i]  = '0;
      tag_b_tbl[i]  = '0;
    end
  endtask

  // apply one word to the predicted table, results land in word_results
  task automatic advance_timer_table(input logic [2:0] op, input logic [3:0] s,
                                     input logic [23:0] cv, input logic [1:0] md,
                                     input logic [31:0] a1, input logic [31:0] a2);
    bit active;
    bit found;
    word_results.delete();
    active = (s != 0) && slot_used[s];
    case (op)
      OP_TICK: begin
        for (int i = 1; i < SLOTS; i++) begin
          if (slot_used[i] && remain_cnt[i] > 0) begin
            remain_cnt[i] = remain_cnt[i] - CNT_W'(1);
            if (remain_cnt[i] == 0) begin
              word_results.push_back(make_result(i[3:0], '0, 1'b1, tag_a_tbl[i],
                                                 tag_b_tbl[i]));
              if (expiry[i] == MODE_FREE) begin
                slot_used[i]  = 1'b0;
                reload_cnt[i] = CNT_STOPPED;
                remain_cnt[i] = CNT_STOPPED;
              end else if (expiry[i] == MODE_PERIODIC) begin
                remain_cnt[i] = reload_cnt[i];
              end else begin
                remain_cnt[i] = CNT_STOPPED;
              end
            end
          end
        end
      end
      OP_ALLOC: begin
        found = 1'b0;
        for (int i = 1; i < SLOTS; i++) begin
          if (!found && !slot_used[i]) begin
            found         = 1'b1;
            slot_used[i]  = 1'b1;
            reload_cnt[i] = {1'b0, cv};
            remain_cnt[i] = {1'b0, cv};
            expiry[i]     = md;
            tag_a_tbl[i]  = a1;
            tag_b_tbl[i]  = a2;
            word_results.push_back(make_result(i[3:0], '0, 1'b0, '0, '0));
          end
        end
        // table full
        if (!found) word_results.push_back(make_result('0, '0, 1'b0, '0, '0));
      end
      OP_READ: begin
        word_results.push_back(make_result(s, active ? remain_cnt[s] : CNT_STOPPED,
                                           1'b0, '0, '0));
      end
      OP_RESTART: begin
        if (active) remain_cnt[s] = reload_cnt[s];
      end
      OP_SUSPEND: begin
        if (active) remain_cnt[s] = CNT_STOPPED;
      end
      OP_NEWTIME: begin
        if (active) begin
          reload_cnt[s] = {1'b0, cv};
          remain_cnt[s] = {1'b0, cv};
        end
      end
      OP_KILL: begin
        if (active) begin
          slot_used[s]  = 1'b0;
          reload_cnt[s] = CNT_STOPPED;
          remain_cnt[s] = CNT_STOPPED;
        end
      end
      default: ;
    endcase
  endtask

  // output check, prediction on input acceptance, watchdog
  always @(posedge clk) begin : monitor
    timer_result_t seen;
    timer_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = '{result_slot, count_read, fired, tag_first_out, tag_second_out, last};
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result word slot %0d cnt %0d fired %0b",
                                    result_slot, count_read, fired));
        end else begin
          want = results_due.pop_front();
          if (seen !== want)
            report_mismatch($sformatf(
              "got slot %0d cnt %0d fired %0b tags %h %h last %0b, want %0d %0d %0b %h %h %0b",
              seen.slot, seen.cnt, seen.fired, seen.tag_a, seen.tag_b, seen.last,
              want.slot, want.cnt, want.fired, want.tag_a, want.tag_b, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        advance_timer_table(operation, slot, count_value, mode, arg_first, arg_second);
        if (chk_kind == CHK_PREDICT) begin
          for (int i = 0; i < word_results.size(); i++) begin
            want      = word_results[i];
            want.last = (i == word_results.size() - 1);
            results_due.push_back(want);
          end
        end else if (chk_kind == CHK_ONE) begin
          want      = make_result(chk_slot, chk_cnt, 1'b0, '0, '0);
          want.last = 1'b1;
          results_due.push_back(want);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // present one word, hold it until accepted
  task automatic send_word(input logic [2:0] op, input logic [3:0] s, input logic [23:0] cv,
                           input logic [1:0] md, input logic [31:0] a1,
                           input logic [31:0] a2, input check_kind_t kind,
                           input logic [3:0] eslot, input logic signed [CNT_W-1:0] ecnt);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    slot        <= s;
    count_value <= cv;
    mode        <= md;
    arg_first   <= a1;
    arg_second  <= a2;
    chk_kind    <= kind;
    chk_slot    <= eslot;
    chk_cnt     <= ecnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic stim_row_t stim_row(input logic [2:0] op, input logic [3:0] s,
                                         input logic [23:0] cv, input logic [1:0] md,
                                         input logic [31:0] a1, input logic [31:0] a2,
                                         input check_kind_t kind, input logic [3:0] eslot,
                                         input logic signed [CNT_W-1:0] ecnt);
    stim_row_t r;
    r = '{op, s, cv, md, a1, a2, kind, eslot, ecnt};
    return r;
  endfunction

  // mostly short counts so slots fire often, sometimes wide or maximal
  function automatic logic [23:0] pick_count();
    logic [23:0] cv;
    case ($urandom_range(19))
      0:       cv = '0;
      1:       cv = 24'($urandom);
      2:       cv = '1;
      default: cv = 24'($urandom_range(6, 1));
    endcase
    return cv;
  endfunction

  initial begin : stimulus
    int          n;
    int          dice;
    logic [2:0]  op;
    logic [3:0]  s;

    clear_timer_table();
    dir_rows = '{
      // read straight after reset
      stim_row(OP_READ,    4'd5,  '0,        MODE_STOP,     '0, '0, CHK_ONE, 4'd5, CNT_STOPPED),
      // tick with nothing to expire
      stim_row(OP_TICK,    4'd0,  '0,        MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      // fill the first slots with extreme tags and counts
      stim_row(OP_ALLOC,   4'd0,  24'd2,     MODE_PERIODIC, 32'h7fffffff, 32'h80000000,
               CHK_ONE, 4'd1, '0),
      stim_row(OP_ALLOC,   4'd0,  24'd0,     MODE_STOP,     32'hffffffff, 32'h0,
               CHK_ONE, 4'd2, '0),
      stim_row(OP_ALLOC,   4'd0,  24'hffffff, MODE_FREE,    32'h80000000, 32'h7fffffff,
               CHK_ONE, 4'd3, '0),
      stim_row(OP_ALLOC,   4'd15, 24'd1,     MODE_STOP_ALT, 32'h12345678, 32'hffffffff,
               CHK_ONE, 4'd4, '0),
      stim_row(OP_ALLOC,   4'd0,  24'd1,     MODE_FREE,     32'h0, 32'hdeadbeef,
               CHK_ONE, 4'd5, '0),
      stim_row(OP_READ,    4'd1,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_READ,    4'd3,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      // two expiries on one tick, then a periodic one
      stim_row(OP_TICK,    4'd0,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_TICK,    4'd0,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_READ,    4'd4,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_READ,    4'd5,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_READ,    4'd2,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_SUSPEND, 4'd1,  '0,        MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_READ,    4'd1,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_RESTART, 4'd1,  '0,        MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_NEWTIME, 4'd3,  24'd1,     MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_TICK,    4'd0,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      stim_row(OP_KILL,    4'd1,  '0,        MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_READ,    4'd1,  '0,        MODE_STOP,     '0, '0, CHK_PREDICT, '0, '0),
      // ignored words
      stim_row(OP_UNUSED,  4'd1,  24'd3,     MODE_FREE,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_NEWTIME, 4'd0,  24'd5,     MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      stim_row(OP_KILL,    4'd15, '0,        MODE_STOP,     '0, '0, CHK_NONE, '0, '0),
      // reads of slot 0 and an unused slot
      stim_row(OP_READ,    4'd0,  '0,        MODE_STOP,     '0, '0, CHK_ONE, 4'd0, CNT_STOPPED),
      stim_row(OP_READ,    4'd15, '0,        MODE_STOP,     '0, '0, CHK_ONE, 4'd15, CNT_STOPPED)
    };

    // reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].count, dir_rows[i].mode,
                dir_rows[i].a1, dir_rows[i].a2, dir_rows[i].kind, dir_rows[i].exp_slot,
                dir_rows[i].exp_cnt);

    // random words, with periodic allocate bursts that run the table full
    n = 0;
    while (n < RAND_WORDS) begin
      calm = (n >= 120 && n < 200);
      if (n % 90 == 45) begin
        repeat (SLOTS) send_word(OP_ALLOC, 4'($urandom), pick_count(),
                                 2'($urandom_range(3)), $urandom, $urandom, CHK_PREDICT,
                                 '0, '0);
      end
      dice = $urandom_range(99);
      if (dice < 38)      op = OP_TICK;
      else if (dice < 56) op = OP_ALLOC;
      else if (dice < 68) op = OP_READ;
      else if (dice < 74) op = OP_RESTART;
      else if (dice < 79) op = OP_SUSPEND;
      else if (dice < 86) op = OP_NEWTIME;
      else if (dice < 95) op = OP_KILL;
      else                op = OP_UNUSED;
      s = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(SLOTS - 1, 1));
      send_word(op, s, pick_count(), 2'($urandom_range(3)), $urandom, $urandom,
                CHK_PREDICT, '0, '0);
      n++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then wait out the length of a full tick sweep for anything stray
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mstt_pkg.sv
rtl/multi_slot_software_timer_table.sv
sim/tb_multi_slot_software_timer_table.sv
